### design/atd_pkg.sv
`timescale 1ns / 1ps
package atd_pkg;

  localparam logic [1:0] CMD_SAMPLE = 2'd0;
  localparam logic [1:0] CMD_HW_TAP = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;

  localparam logic REG_SENS_LEVEL = 1'b0;
  localparam logic REG_TAP_ENABLE = 1'b1;

  localparam logic [16:0] BASELINE_RESET = 17'd2509;
  localparam logic [1:0]  SENS_RESET     = 2'd2;

  typedef struct packed {
    logic [15:0] alpha;  // Q0.16
    logic [8:0]  thr;    // Q9.0 (unsigned integer)
    logic [7:0]  refr;   // ms
  } preset_t;

  typedef struct packed {
    logic       load;
    logic       sq;
    logic [1:0] axis;
    logic       sqrt;
    logic       mul;
    logic       upd;
    logic       commit;
  } dp_cmd_t;

  typedef struct packed {
    logic sample;    // incoming transaction is a handled sample
    logic out_busy;  // result register still holds an untaken result
  } dp_sts_t;

  // level 0 saturates to level 1
  function automatic preset_t preset_lookup(input logic [1:0] lvl);
    preset_t p;
    case (lvl)
      2'd0, 2'd1: p = '{alpha: 16'd11796, thr: 9'd256, refr: 8'd180};
      2'd3:       p = '{alpha: 16'd19661, thr: 9'd90,  refr: 8'd80};
      default:    p = '{alpha: 16'd16384, thr: 9'd154, refr: 8'd120};
    endcase
    return p;
  endfunction

endpackage

### design/atd_ctrl.sv
`timescale 1ns / 1ps
module atd_ctrl import atd_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SQ   = 3'd1;
  localparam logic [2:0] S_SQRT = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_UPD  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic [3:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          cnt_nxt  = 4'd0;
          state_nxt = sts.sample ? S_SQ : S_FIN;
        end
      end
      S_SQ: begin
        cmd.sq   = 1'b1;
        cmd.axis = cnt_r[1:0];
        if (cnt_r == 4'd2) begin
          cnt_nxt   = 4'd0;
          state_nxt = S_SQRT;
        end else begin
          cnt_nxt = cnt_r + 4'd1;
        end
      end
      S_SQRT: begin
        cmd.sqrt = 1'b1;
        cnt_nxt  = cnt_r + 4'd1;
        if (cnt_r == 4'd15) state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!sts.out_busy) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= 4'd0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  a_sample_starts: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load && sts.sample |=> state_r == S_SQ && cnt_r == 4'd0)
    else $error("sample transaction did not start squaring");

  a_sq_to_sqrt: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SQ && cnt_r == 4'd2 |=> state_r == S_SQRT && cnt_r == 4'd0)
    else $error("root iterations did not follow squaring");

  a_sqrt_done: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SQRT && cnt_r == 4'd15 |=> state_r == S_MUL)
    else $error("root did not end after sixteen steps");

  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> state_r == S_IDLE && $past(!sts.out_busy))
    else $error("commit into an occupied result register");

endmodule

### design/atd_dp.sv
`timescale 1ns / 1ps
module atd_dp import atd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  dp_cmd_t            cmd,
  output dp_sts_t            sts,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [1:0]         cfg_wdata,
  input  logic [1:0]         in_command,
  input  logic signed [15:0] in_accel_x,
  input  logic signed [15:0] in_accel_y,
  input  logic signed [15:0] in_accel_z,
  input  logic [31:0]        in_now_ms,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_flag_now,
  output logic               out_read_value,
  output logic [15:0]        out_magnitude
);

  logic [1:0]  sens_level_r;
  logic        tap_enable_r;
  logic [16:0] base_r, base_nxt;
  logic [31:0] last_tap_r;
  logic        pending_r;

  logic [1:0]  cmd_r;
  logic        samp_r;
  logic [31:0] now_r;
  logic [15:0] ax_r, ay_r, az_r;
  logic [31:0] v_r, root_r, bit_r;
  logic        ge_r;
  logic [32:0] prod_r;

  logic        out_valid_r;
  logic        out_flag_r, out_rd_r;
  logic [15:0] out_mag_r;

  preset_t     pre;
  logic [15:0] opnd, mag;
  logic [31:0] sq, trial;
  logic [16:0] diff, step;
  logic [33:0] rnd;
  logic signed [17:0] spike;
  logic [31:0] elapsed;
  logic        detect, pend_nxt, rd_nxt;

  function automatic logic [15:0] abs16(input logic signed [15:0] a);
    return a[15] ? (~a + 16'd1) : a;
  endfunction

  assign pre = preset_lookup(sens_level_r);
  assign mag = root_r[15:0];

  assign sts.sample   = (in_command == CMD_SAMPLE) && tap_enable_r;
  assign sts.out_busy = out_valid_r && out_stall;

  always_comb begin
    case (cmd.axis)
      2'd0:    opnd = ax_r;
      2'd1:    opnd = ay_r;
      default: opnd = az_r;
    endcase
  end
  assign sq    = {16'd0, opnd} * {16'd0, opnd};
  assign trial = root_r + bit_r;

  assign diff = ({1'b0, mag} >= base_r) ? ({1'b0, mag} - base_r) : (base_r - {1'b0, mag});
  assign rnd  = {1'b0, prod_r} + 34'd32768;
  assign step = rnd[32:16];
  assign base_nxt = ge_r ? (base_r + step) : (base_r - step);

  // decision uses the updated baseline
  assign spike   = $signed({2'b00, mag}) - $signed({1'b0, base_r});
  assign elapsed = now_r - last_tap_r;
  assign detect  = samp_r && (spike > $signed({9'd0, pre.thr}))
                   && (elapsed > {24'd0, pre.refr});

  always_comb begin
    pend_nxt = pending_r;
    rd_nxt   = 1'b0;
    if (samp_r) begin
      if (detect) pend_nxt = 1'b1;
    end else begin
      case (cmd_r)
        CMD_HW_TAP: pend_nxt = 1'b1;
        CMD_READ: begin
          rd_nxt   = pending_r;
          pend_nxt = 1'b0;
        end
        default: pend_nxt = pending_r;
      endcase
    end
  end

  // control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sens_level_r <= SENS_RESET;
      tap_enable_r <= 1'b1;
      base_r       <= BASELINE_RESET;
      last_tap_r   <= 32'd0;
      pending_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_SENS_LEVEL) sens_level_r <= cfg_wdata;
        else                             tap_enable_r <= cfg_wdata[0];
      end
      if (cmd.upd) base_r <= base_nxt;
      if (cmd.commit) begin
        pending_r <= pend_nxt;
        if (detect) last_tap_r <= now_r;
      end
      if (cmd.commit)               out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r  <= in_command;
      samp_r <= sts.sample;
      now_r  <= in_now_ms;
      ax_r   <= abs16(in_accel_x);
      ay_r   <= abs16(in_accel_y);
      az_r   <= abs16(in_accel_z);
      v_r    <= 32'd0;
      root_r <= 32'd0;
      bit_r  <= 32'h4000_0000;
    end
    if (cmd.sq) v_r <= v_r + sq;
    if (cmd.sqrt) begin
      if (v_r >= trial) begin
        v_r    <= v_r - trial;
        root_r <= (root_r >> 1) + bit_r;
      end else begin
        root_r <= root_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
    if (cmd.mul) begin
      ge_r   <= ({1'b0, mag} >= base_r);
      prod_r <= {17'd0, pre.alpha} * {16'd0, diff};
    end
    if (cmd.commit) begin
      out_flag_r <= pend_nxt;
      out_rd_r   <= rd_nxt;
      out_mag_r  <= samp_r ? mag : 16'd0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_flag_now   = out_flag_r;
  assign out_read_value = out_rd_r;
  assign out_magnitude  = out_mag_r;

  a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r && out_flag_r == pending_r)
    else $error("result flag disagrees with tap state");

  a_read_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && !samp_r && cmd_r == CMD_READ |=> !pending_r)
    else $error("read did not clear tap flag");

  a_base_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.upd && ge_r |=> base_r <= {1'b0, mag})
    else $error("baseline overshot magnitude");

endmodule

### design/accel_tap_detector_core.sv
`timescale 1ns / 1ps
// Sample transaction: loaded on acceptance, then the shared squarer sums the three axis squares
// and the bit-serial square root runs, then multiply, update and commit when the result register
// is free. The next transaction is accepted only after commit, once the block is back in idle.
// Tap event, read, disabled sample: loaded on acceptance, then committed when the register is free.
// Synchronous active-low reset: sens_level 2, tap_enable 1, baseline 2509, flag clear.
module accel_tap_detector_core import atd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [1:0]         cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_command,
  input  logic signed [15:0] in_accel_x,
  input  logic signed [15:0] in_accel_y,
  input  logic signed [15:0] in_accel_z,
  input  logic [31:0]        in_now_ms,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_flag_now,
  output logic               out_read_value,
  output logic [15:0]        out_magnitude
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  atd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  atd_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_command     (in_command),
    .in_accel_x     (in_accel_x),
    .in_accel_y     (in_accel_y),
    .in_accel_z     (in_accel_z),
    .in_now_ms      (in_now_ms),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_flag_now   (out_flag_now),
    .out_read_value (out_read_value),
    .out_magnitude  (out_magnitude)
  );

endmodule

### tb/tb_accel_tap_detector_core.sv
`timescale 1ns / 1ps
module tb_accel_tap_detector_core;
  import atd_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [1:0] SENS_LOW   = 2'd1;
  localparam logic [1:0] SENS_HIGH  = 2'd3;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int N_DIRECTED    = 25;
  localparam int N_PHASES      = 9;
  localparam int PHASE_ITEMS   = 115;
  localparam int DRAIN_CYCLES  = 30;

  // per-phase register settings and idle rates (percent of cycles)
  localparam logic [1:0] PH_SENS [N_PHASES] = '{2'd2, 2'd1, 2'd3, 2'd0, 2'd3,
                                                 2'd2, 2'd1, 2'd3, 2'd0};
  localparam logic PH_EN [N_PHASES] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1,
                                        1'b0, 1'b1, 1'b1, 1'b1};
  localparam int PH_SEND_IDLE [N_PHASES] = '{16, 16, 16, 88, 88, 88, 0, 0, 0};
  localparam int PH_RECV_IDLE [N_PHASES] = '{88, 88, 88, 16, 16, 16, 0, 0, 0};

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic [31:0]        now;
  } tap_item_t;

  typedef struct packed {
    logic        flag;
    logic        rd;
    logic [15:0] mag;
  } tap_result_t;

  typedef struct packed {
    tap_item_t   item;
    logic        typed;
    tap_result_t want;
  } dir_row_t;

  // typed rows hold values that follow directly from reset state and extremes
  localparam dir_row_t DIR_ROWS [N_DIRECTED] = '{
    '{'{CMD_READ,   16'sd0, 16'sd0, 16'sd0, 32'd0},            1'b1, '{1'b0, 1'b0, 16'd0}},
    '{'{CMD_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF}, 1'b1, '{1'b0, 1'b0, 16'd0}},
    '{'{CMD_HW_TAP, 16'sd0, 16'sd0, 16'sd0, 32'd0},            1'b1, '{1'b1, 1'b0, 16'd0}},
    '{'{CMD_HW_TAP, 16'h7FFF, 16'h8000, 16'h7FFF, 32'd5},      1'b1, '{1'b1, 1'b0, 16'd0}},
    '{'{CMD_READ,   16'sd0, 16'sd0, 16'sd0, 32'd0},            1'b1, '{1'b0, 1'b1, 16'd0}},
    '{'{CMD_READ,   16'sd0, 16'sd0, 16'sd0, 32'd0},            1'b1, '{1'b0, 1'b0, 16'd0}},
    '{'{CMD_SAMPLE, 16'sd0, 16'sd0, 16'sd2509, 32'd10},        1'b1, '{1'b0, 1'b0, 16'd2509}},
    '{'{CMD_SAMPLE, 16'sd0, 16'sd0, -16'sd2509, 32'd20},       1'b1, '{1'b0, 1'b0, 16'd2509}},
    '{'{CMD_SAMPLE, 16'sd0, 16'sd0, 16'sd0, 32'd30},           1'b1, '{1'b0, 1'b0, 16'd0}},
    '{'{CMD_SAMPLE, 16'h8000, 16'h8000, 16'h8000, 32'd50},     1'b1, '{1'b0, 1'b0, 16'd56755}},
    '{'{CMD_SAMPLE, 16'h7FFF, 16'h7FFF, 16'h7FFF, 32'd120},    1'b1, '{1'b0, 1'b0, 16'd56754}},
    '{'{CMD_SAMPLE, 16'h7FFF, 16'sd0, 16'sd0, 32'd121},        1'b0, '0},
    '{'{CMD_SAMPLE, 16'h8000, 16'h8000, 16'h8000, 32'd200},    1'b0, '0},
    '{'{CMD_SAMPLE, 16'sd0, 16'h8000, 16'sd0, 32'd201},        1'b0, '0},
    '{'{CMD_SAMPLE, 16'sd0, 16'sd0, 16'h7FFF, 32'd300},        1'b0, '0},
    '{'{CMD_READ,   16'sd0, 16'sd0, 16'sd0, 32'd0},            1'b0, '0},
    '{'{CMD_SAMPLE, 16'sd1, -16'sd1, 16'sd1, 32'd400},         1'b0, '0},
    '{'{CMD_SAMPLE, 16'sd0, 16'sd0, 16'sd0, 32'd500},          1'b0, '0},
    '{'{CMD_SAMPLE, 16'sd0, 16'sd0, 16'sd0, 32'd600},          1'b0, '0},
    '{'{CMD_SAMPLE, 16'sd0, 16'sd0, 16'sd0, 32'd700},          1'b0, '0},
    '{'{CMD_SAMPLE, 16'h8000, 16'h8000, 16'h8000, 32'hFFFFFF00}, 1'b0, '0},
    '{'{CMD_READ,   16'sd0, 16'sd0, 16'sd0, 32'd0},            1'b0, '0},
    '{'{CMD_SAMPLE, 16'h8000, 16'h7FFF, 16'h8000, 32'h00000010}, 1'b0, '0},
    '{'{CMD_SAMPLE, 16'h8000, 16'h8000, 16'h8000, 32'h00000030}, 1'b0, '0},
    '{'{CMD_READ,   16'sd0, 16'sd0, 16'sd0, 32'd0},            1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_index = REG_SENS_LEVEL;
  logic [1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_command = CMD_SAMPLE;
  logic signed [15:0] in_accel_x = '0;
  logic signed [15:0] in_accel_y = '0;
  logic signed [15:0] in_accel_z = '0;
  logic [31:0] in_now_ms = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_flag_now;
  logic out_read_value;
  logic [15:0] out_magnitude;

  accel_tap_detector_core dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_command    (in_command),
    .in_accel_x    (in_accel_x),
    .in_accel_y    (in_accel_y),
    .in_accel_z    (in_accel_z),
    .in_now_ms     (in_now_ms),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_flag_now  (out_flag_now),
    .out_read_value(out_read_value),
    .out_magnitude (out_magnitude)
  );

  // detector state as the testbench sees it
  logic [1:0]  sens_q = SENS_RESET;
  logic        en_q = 1'b1;
  logic [16:0] baseline_q = BASELINE_RESET;
  logic [31:0] last_tap_ms = '0;
  logic        tap_flag = 1'b0;

  tap_result_t result_q[$];
  tap_result_t oldest;
  int mismatches = 0;
  int result_cnt = 0;
  int cycle_cnt = 0;
  int send_idle_pct = 16;
  int recv_idle_pct = 88;
  logic [31:0] clock_ms = 32'd1000;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic [15:0] int_sqrt(input logic [31:0] v);
    logic [15:0] root;
    logic [15:0] trial;
    root = '0;
    for (int b = 15; b >= 0; b--) begin
      trial = root | (16'd1 << b);
      if (32'(trial) * 32'(trial) <= v) root = trial;
    end
    return root;
  endfunction

  function automatic logic [31:0] abs_axis(input logic signed [15:0] a);
    int v;
    v = a;
    return (v < 0) ? -v : v;
  endfunction

  // advances the detector state by one transaction and returns its result
  function automatic tap_result_t predict_tap(input tap_item_t it);
    tap_result_t r;
    logic [31:0] ax, ay, az, sum, d, thr, refr;
    logic [15:0] alpha, mag;
    logic [63:0] stepv;
    int spike;
    r = '0;
    case (it.cmd)
      CMD_SAMPLE: begin
        if (en_q) begin
          ax = abs_axis(it.x);
          ay = abs_axis(it.y);
          az = abs_axis(it.z);
          sum = ax * ax + ay * ay + az * az;
          mag = int_sqrt(sum);
          // level 0 behaves as the low preset
          if (sens_q == SENS_HIGH) begin
            alpha = 16'd19661; thr = 90; refr = 80;
          end else if (sens_q <= SENS_LOW) begin
            alpha = 16'd11796; thr = 256; refr = 180;
          end else begin
            alpha = 16'd16384; thr = 154; refr = 120;
          end
          if (17'(mag) >= baseline_q) begin
            d = 32'(mag) - 32'(baseline_q);
            stepv = 64'(alpha) * 64'(d) + 64'd32768;
            baseline_q = baseline_q + stepv[32:16];
          end else begin
            d = 32'(baseline_q) - 32'(mag);
            stepv = 64'(alpha) * 64'(d) + 64'd32768;
            baseline_q = baseline_q - stepv[32:16];
          end
          spike = int'(mag) - int'(baseline_q);
          if (spike > int'(thr) && (it.now - last_tap_ms) > refr) begin
            tap_flag = 1'b1;
            last_tap_ms = it.now;
          end
          r.mag = mag;
        end
      end
      CMD_HW_TAP: tap_flag = 1'b1;
      CMD_READ: begin
        r.rd = tap_flag;
        tap_flag = 1'b0;
      end
      default: ;
    endcase
    r.flag = tap_flag;
    return r;
  endfunction

  // mostly gravity-like samples with occasional spikes, plus commands and noise
  function automatic tap_item_t random_item();
    tap_item_t it;
    int pick, zv;
    it = '0;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      it.cmd = CMD_SAMPLE;
      if ($urandom_range(0, 99) == 0) clock_ms = clock_ms + $urandom();
      else clock_ms = clock_ms + $urandom_range(1, 45);
      it.now = clock_ms;
      it.x = 16'($urandom_range(0, 400) - 200);
      it.y = 16'($urandom_range(0, 400) - 200);
      zv = 2509 + $urandom_range(0, 160) - 80;
      if ($urandom_range(0, 7) == 0) zv = zv + $urandom_range(50, 3000);
      it.z = 16'($urandom_range(0, 1) ? zv : -zv);
    end else if (pick < 72) begin
      it.cmd = CMD_SAMPLE;
      it.x = 16'($urandom());
      it.y = 16'($urandom());
      it.z = 16'($urandom());
      it.now = $urandom();
    end else begin
      if (pick < 80) it.cmd = CMD_HW_TAP;
      else if (pick < 95) it.cmd = CMD_READ;
      else it.cmd = CMD_UNUSED;
      it.x = 16'($urandom());
      it.y = 16'($urandom());
      it.z = 16'($urandom());
      it.now = $urandom();
    end
    return it;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches < 100)
      $display("mismatch on %s: got %0d, expected %0d (result %0d, t=%0t)",
               what, got, want, result_cnt, $realtime);
    mismatches++;
  endtask

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(input tap_item_t it, input logic typed, input tap_result_t want);
    tap_result_t pred;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_command <= it.cmd;
    in_accel_x <= it.x;
    in_accel_y <= it.y;
    in_accel_z <= it.z;
    in_now_ms <= it.now;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = predict_tap(it);
    result_q.push_back(typed ? want : pred);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (result_q.size() != 0);
  endtask

  // block is idle here; both registers written on consecutive cycles
  task automatic set_config(input logic [1:0] sens, input logic en);
    cfg_we <= 1'b1;
    cfg_index <= REG_SENS_LEVEL;
    cfg_wdata <= sens;
    @(negedge clk);
    cfg_index <= REG_TAP_ENABLE;
    cfg_wdata <= {1'b0, en};
    @(negedge clk);
    cfg_we <= 1'b0;
    sens_q = sens;
    en_q = en;
  endtask

  always @(negedge clk) out_stall <= ($urandom_range(0, 99) < recv_idle_pct);

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (result_q.size() == 0) begin
        report_mismatch("unexpected transaction", 1, 0);
      end else begin
        oldest = result_q.pop_front();
        if (out_flag_now !== oldest.flag)
          report_mismatch("flag_now", out_flag_now, oldest.flag);
        if (out_read_value !== oldest.rd)
          report_mismatch("read_value", out_read_value, oldest.rd);
        if (out_magnitude !== oldest.mag)
          report_mismatch("magnitude", out_magnitude, oldest.mag);
      end
      result_cnt++;
    end
  end

  initial begin
    tap_item_t it;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < N_DIRECTED; i++)
      send_item(DIR_ROWS[i].item, DIR_ROWS[i].typed, DIR_ROWS[i].want);

    for (int p = 0; p < N_PHASES; p++) begin
      wait_drained();
      set_config(PH_SENS[p], PH_EN[p]);
      send_idle_pct = PH_SEND_IDLE[p];
      recv_idle_pct = PH_RECV_IDLE[p];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        it = random_item();
        send_item(it, 1'b0, '0);
        if ($urandom_range(0, 49) == 0) wait_drained();
      end
    end

    in_valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && result_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### accel_tap_detector_core.f
design/atd_pkg.sv
design/atd_ctrl.sv
design/atd_dp.sv
design/accel_tap_detector_core.sv
tb/tb_accel_tap_detector_core.sv
